// ----- sv/cesf_pkg.sv -----
package cesf_pkg;

  localparam int MaxOrbitals = 64;
  localparam int MaskW       = 64;
  localparam int CntW        = 7;
  localparam int IdxW        = $clog2(MaskW);
  localparam int PopW        = $clog2(MaskW + 1);
  localparam int SpinW       = 10;

  // register indexes on the configuration port
  localparam logic [2:0] RegNumOrbitals  = 3'd0;
  localparam logic [2:0] RegNumParticles = 3'd1;
  localparam logic [2:0] RegConserveSpin = 3'd2;
  localparam logic [2:0] RegTargetSpin   = 3'd3;
  localparam logic [2:0] RegUpSpinMask   = 3'd4;

  typedef struct packed {
    logic [CntW-1:0]   num_orbitals;
    logic [CntW-1:0]   num_particles;
    logic              conserve_spin;
    logic signed [7:0] target_spin;
    logic [MaskW-1:0]  up_spin_mask;
  } cesf_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SCORE
  } cesf_state_e;

  typedef enum logic [1:0] {
    OP_START,
    OP_ADVANCE,
    OP_HOLD
  } cesf_op_e;

  typedef struct packed {
    logic capture;   // item taken: latch scan of current mask
    logic build;     // write next mask and walk flags
    logic load_out;  // load result register
  } cesf_cmd_t;

  typedef struct packed {
    cesf_op_e          op;
    logic              fail;
    logic [CntW-1:0]   t;
    logic [IdxW-1:0]   p;
  } cesf_scan_t;

  // bit j set for every j below v
  function automatic logic [MaskW-1:0] low_bits(input logic [CntW-1:0] v);
    logic [MaskW-1:0] r;
    for (int j = 0; j < MaskW; j++) begin
      r[j] = (CntW'(j) < v);
    end
    return r;
  endfunction

  // index of the highest set bit, zero when none
  function automatic logic [IdxW-1:0] msb_idx(input logic [MaskW-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int j = 0; j < MaskW; j++) begin
      if (v[j]) begin
        r = IdxW'(j);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      r = r + {3'b000, v[j]};
    end
    return r;
  endfunction

  function automatic logic [PopW-1:0] popcount(input logic [MaskW-1:0] v);
    logic [PopW-1:0] r;
    r = '0;
    for (int j = 0; j < MaskW / 8; j++) begin
      r = r + PopW'(pop8(v[8*j +: 8]));
    end
    return r;
  endfunction

endpackage

// ----- sv/cesf_if.sv -----
interface cesf_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface cesf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] occupancy_mask;
  logic        accepted;
  logic        finished;

  modport source (output valid, output occupancy_mask, output accepted, output finished,
                  input ready);
  modport sink (input valid, input occupancy_mask, input accepted, input finished,
                output ready);
endinterface

// ----- sv/cesf_regs.sv -----
module cesf_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [5:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  output cesf_pkg::cesf_cfg_t     cfg_o
);
  import cesf_pkg::*;

  cesf_cfg_t  cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegNumOrbitals:  cfg_d.num_orbitals  = pwdata[CntW-1:0];
        RegNumParticles: cfg_d.num_particles = pwdata[CntW-1:0];
        RegConserveSpin: cfg_d.conserve_spin = pwdata[0];
        RegTargetSpin:   cfg_d.target_spin   = pwdata[7:0];
        RegUpSpinMask:   cfg_d.up_spin_mask  = pwdata[MaskW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegNumOrbitals:  prdata = 64'(cfg_q.num_orbitals);
      RegNumParticles: prdata = 64'(cfg_q.num_particles);
      RegConserveSpin: prdata = 64'(cfg_q.conserve_spin);
      RegTargetSpin:   prdata = 64'(cfg_q.target_spin);
      RegUpSpinMask:   prdata = cfg_q.up_spin_mask;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_orbitals  <= CntW'(MaxOrbitals);
      cfg_q.num_particles <= CntW'(2);
      cfg_q.conserve_spin <= 1'b0;
      cfg_q.target_spin   <= '0;
      cfg_q.up_spin_mask  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- sv/cesf_ctrl.sv -----
module cesf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cesf_pkg::cesf_cmd_t cmd_o
);
  import cesf_pkg::*;

  cesf_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        take;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign take        = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_BUILD;
        end
      end
      ST_BUILD: begin
        state_d = ST_SCORE;
      end
      ST_SCORE: begin
        if (slot_free) begin
          state_d = in_valid_i ? ST_BUILD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_BUILD: begin
        cmd_o.build = 1'b1;
      end
      ST_SCORE: begin
        in_ready_o     = slot_free;
        cmd_o.load_out = slot_free;
      end
      default: ;
    endcase
    cmd_o.capture = take;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/cesf_dp.sv -----
module cesf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cesf_pkg::cesf_cmd_t cmd_i,
  input  cesf_pkg::cesf_cfg_t cfg_i,
  input  logic                restart_i,
  output logic [63:0]         occupancy_mask_o,
  output logic                accepted_o,
  output logic                finished_o
);
  import cesf_pkg::*;

  logic [MaskW-1:0] cur_q, cur_d;
  logic             started_q, started_d;
  logic             exhausted_q, exhausted_d;
  cesf_scan_t       scan_q, scan_d;
  logic [MaskW-1:0] omask_q, omask_d;
  logic             oacc_q, oacc_d;
  logic             ofin_q, ofin_d;

  logic [CntW-1:0]  n_eff;
  logic [CntW-1:0]  k;
  logic [MaskW-1:0] win;
  logic [MaskW-1:0] zeros;
  logic [MaskW-1:0] below;
  logic [IdxW-1:0]  top_zero;
  logic [CntW-1:0]  run_len;
  logic             z_any;
  logic             p_any;

  logic [CntW-1:0]  fill_lo;
  logic [CntW-1:0]  fill_hi;
  logic [MaskW-1:0] next_mask;

  logic [PopW-1:0]  pop;
  logic [SpinW-1:0] spin;
  logic [SpinW-1:0] target;

  assign n_eff = (cfg_i.num_orbitals > CntW'(MaxOrbitals)) ? CntW'(MaxOrbitals)
                                                           : cfg_i.num_orbitals;
  assign k     = cfg_i.num_particles;
  assign win   = low_bits(n_eff);

  // scan: run of ones at the top of the window, and the highest one below it
  assign zeros    = ~cur_q & win;
  assign z_any    = |zeros;
  assign top_zero = msb_idx(zeros);
  assign run_len  = z_any ? (n_eff - CntW'(1) - CntW'(top_zero)) : n_eff;
  assign below    = cur_q & win & low_bits(CntW'(top_zero));
  assign p_any    = |below;

  always_comb begin
    scan_d   = scan_q;
    if (cmd_i.capture) begin
      scan_d.t = run_len;
      scan_d.p = msb_idx(below);
      if (restart_i || !started_q) begin
        scan_d.op   = OP_START;
        scan_d.fail = (k > n_eff);
      end else if (exhausted_q) begin
        scan_d.op   = OP_HOLD;
        scan_d.fail = 1'b1;
      end else begin
        scan_d.op   = OP_ADVANCE;
        scan_d.fail = !z_any || (run_len >= k) || !p_any;
      end
    end
  end

  // build: keep bits below p, then a block of t+1 ones from p+1
  assign fill_lo   = CntW'(scan_q.p) + CntW'(1);
  assign fill_hi   = CntW'(8'(scan_q.p) + 8'(scan_q.t) + 8'd2);
  assign next_mask = (cur_q & win & low_bits(CntW'(scan_q.p)))
                   | (low_bits(fill_hi) & ~low_bits(fill_lo));

  always_comb begin
    cur_d       = cur_q;
    started_d   = started_q;
    exhausted_d = exhausted_q;
    if (cmd_i.build) begin
      unique case (scan_q.op)
        OP_START: begin
          started_d   = 1'b1;
          exhausted_d = scan_q.fail;
          cur_d       = scan_q.fail ? '0 : low_bits(k);
        end
        OP_ADVANCE: begin
          exhausted_d = scan_q.fail;
          cur_d       = scan_q.fail ? '0 : next_mask;
        end
        default: ;
      endcase
    end
  end

  // score
  assign pop    = popcount(cur_q & cfg_i.up_spin_mask);
  assign spin   = {2'b00, pop, 1'b0} - {3'b000, k};
  assign target = {{(SpinW-8){cfg_i.target_spin[7]}}, cfg_i.target_spin};

  always_comb begin
    omask_d = omask_q;
    oacc_d  = oacc_q;
    ofin_d  = ofin_q;
    if (cmd_i.load_out) begin
      if (exhausted_q) begin
        omask_d = '0;
        oacc_d  = 1'b0;
        ofin_d  = 1'b1;
      end else begin
        omask_d = cur_q;
        oacc_d  = !cfg_i.conserve_spin || (spin == target);
        ofin_d  = 1'b0;
      end
    end
  end

  assign occupancy_mask_o = omask_q;
  assign accepted_o       = oacc_q;
  assign finished_o       = ofin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      started_q   <= 1'b0;
      exhausted_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      started_q   <= started_d;
      exhausted_q <= exhausted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    omask_q <= omask_d;
    oacc_q  <= oacc_d;
    ofin_q  <= ofin_d;
  end

endmodule

// ----- sv/combination_enumerator_spin_filter.sv -----
// Lexicographic k-of-n combination walker with a total spin check.
//
// Input channel in_ch carries one item per step: restart=1 goes back to the
// lowest combination (orbitals 0..k-1), restart=0 moves to the next one by
// the odometer rule. The first item after reset always starts the walk.
// Output channel out_ch returns exactly one item per input item: the
// occupancy mask, accepted (spin filter passed, or filter off) and finished
// (walk exhausted; mask and accepted are then zero, and further advances
// repeat it until a restart).
// Timing: an item is taken, the next mask is built in the following cycle
// from the scan latched at acceptance, and in the score step that follows,
// once the output register is free, the mask is scored (64-bit popcount)
// and loaded into the output register. No new item is taken in the build
// step, as the build and score steps share the single mask register.
// A waiting result does not block the next item from being taken; if the
// receiver stalls while a second result is ready, the block holds in the
// score step with in_ch.ready low until the output register frees.
// Reset clears the walk and the output valid flag; registers return to
// 64 orbitals, 2 particles, filter off, target 0, no up spins. The user
// must write the APB port only while the block is idle; it is not enforced.
module combination_enumerator_spin_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  cesf_in_if.sink            in_ch,
  cesf_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import cesf_pkg::*;

  cesf_cfg_t cfg;
  cesf_cmd_t cmd;

  // configuration registers
  cesf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencing and output handshake
  cesf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd)
  );

  // mask scan, build and scoring
  cesf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg),
    .restart_i        (in_ch.restart),
    .occupancy_mask_o (out_ch.occupancy_mask),
    .accepted_o       (out_ch.accepted),
    .finished_o       (out_ch.finished)
  );

endmodule
